>>> rtl/core/robcd_pkg.sv
// robcd_pkg: shared types, codes and default sizes for the reorder buffer.
// No dependencies; every other file of the block imports it.
package robcd_pkg;

    // Default sizes handed down from the top level
    localparam int ROB_DEPTH_DEF  = 16;
    localparam int REG_COUNT_DEF  = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths of the transactions
    localparam int MODE_W   = 3;
    localparam int REG_W    = 5;
    localparam int IDX_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 3'd0,
        MODE_WBACK  = 3'd1,
        MODE_MARK   = 3'd2,
        MODE_COMMIT = 3'd3,
        MODE_FLUSH  = 3'd4,
        MODE_TICK   = 3'd5,
        MODE_READ   = 3'd6,
        MODE_NOP    = 3'd7
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [REG_W-1:0]         dest_reg;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] write_value;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [IDX_W-1:0]         out_index;
        logic [REG_W-1:0]         out_reg;
        logic signed [DATA_W-1:0] out_value;
        logic                     head_exception;
        logic                     entry_ready;
        logic                     head_ready;
        logic                     is_empty;
        logic                     is_full;
    } t_result;

endpackage

>>> rtl/core/robcd_in_if.sv
// robcd_in_if: input channel of the reorder buffer (valid, ready, operation payload).
// Depends on robcd_pkg for field widths.
interface robcd_in_if;
    import robcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [REG_W-1:0]         dest_reg;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] write_value;

    modport source (output valid, output mode, output dest_reg, output entry_index,
                    output write_value, input ready);
    modport sink   (input valid, input mode, input dest_reg, input entry_index,
                    input write_value, output ready);
endinterface

>>> rtl/core/robcd_out_if.sv
// robcd_out_if: result channel of the reorder buffer (valid, ready, result payload).
// Depends on robcd_pkg for field widths.
interface robcd_out_if;
    import robcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [IDX_W-1:0]         out_index;
    logic [REG_W-1:0]         out_reg;
    logic signed [DATA_W-1:0] out_value;
    logic                     head_exception;
    logic                     entry_ready;
    logic                     head_ready;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output status, output out_index, output out_reg,
                    output out_value, output head_exception, output entry_ready,
                    output head_ready, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input out_index, input out_reg,
                    input out_value, input head_exception, input entry_ready,
                    input head_ready, input is_empty, input is_full, output ready);
endinterface

>>> rtl/core/robcd_value_mem.sv
// robcd_value_mem: result value store, one write port and two registered read ports.
// Depends on robcd_pkg; the write port bypasses into a read of the same entry.
module robcd_value_mem #(
    parameter int ROB_DEPTH  = robcd_pkg::ROB_DEPTH_DEF,
    parameter int VALUE_BITS = robcd_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(ROB_DEPTH)-1:0] i_wr_addr,
    input  logic [VALUE_BITS-1:0]        i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(ROB_DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(ROB_DEPTH)-1:0] i_rd_addr_b,
    output logic [VALUE_BITS-1:0]        o_rd_data_a,
    output logic [VALUE_BITS-1:0]        o_rd_data_b
);
    import robcd_pkg::*;

    logic [VALUE_BITS-1:0] r_mem [ROB_DEPTH];
    logic [VALUE_BITS-1:0] r_rd_a;
    logic [VALUE_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Forward a same-cycle write so the read sees the updated entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= (i_wr_en && (i_wr_addr == i_rd_addr_a)) ? i_wr_data : r_mem[i_rd_addr_a];
            r_rd_b <= (i_wr_en && (i_wr_addr == i_rd_addr_b)) ? i_wr_data : r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;
endmodule

>>> rtl/core/robcd_ctrl.sv
// robcd_ctrl: entry flags, register store, pointers and occupancy; forms each result.
// Depends on robcd_pkg; value reads arrive registered from robcd_value_mem.
module robcd_ctrl #(
    parameter int ROB_DEPTH  = robcd_pkg::ROB_DEPTH_DEF,
    parameter int REG_COUNT  = robcd_pkg::REG_COUNT_DEF,
    parameter int VALUE_BITS = robcd_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  robcd_pkg::t_item               i_item,
    input  logic [$clog2(ROB_DEPTH+1)-1:0] i_used,
    input  logic [VALUE_BITS-1:0]          i_head_data,
    input  logic [VALUE_BITS-1:0]          i_idx_data,
    output robcd_pkg::t_result             o_result,
    output logic [$clog2(ROB_DEPTH)-1:0]   o_head_next,
    output logic                           o_wr_en,
    output logic [$clog2(ROB_DEPTH)-1:0]   o_wr_addr,
    output logic [VALUE_BITS-1:0]          o_wr_data
);
    import robcd_pkg::*;

    localparam int PW = $clog2(ROB_DEPTH);
    localparam int CW = $clog2(ROB_DEPTH+1);
    localparam int RB = $clog2(REG_COUNT);

    logic [ROB_DEPTH-1:0] r_valid, n_valid;
    logic [ROB_DEPTH-1:0] r_done,  n_done;
    logic [ROB_DEPTH-1:0] r_aged,  n_aged;
    logic [ROB_DEPTH-1:0] r_fault, n_fault;
    logic [RB-1:0]        r_reg [ROB_DEPTH];
    logic [PW-1:0]        r_head, n_head;
    logic [PW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_occ,  n_occ;

    logic          reg_we;
    logic [RB-1:0] reg_wdata;
    logic          wb_en;
    logic          idx_ok;
    logic [PW-1:0] iaddr;
    logic          hexc;
    logic          hrdy;
    t_result       res;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] used);
        logic [31:0] nxt;
        nxt = 32'(p) + 32'd1;
        return (nxt >= 32'(used)) ? '0 : PW'(nxt);
    endfunction

    assign idx_ok    = 32'(i_item.entry_index) < 32'(ROB_DEPTH);
    assign iaddr     = PW'(i_item.entry_index);
    assign reg_wdata = (32'(i_item.dest_reg) >= 32'(REG_COUNT)) ? RB'(REG_COUNT - 1)
                                                                : RB'(i_item.dest_reg);

    always_comb begin
        n_valid = r_valid;
        n_done  = r_done;
        n_aged  = r_aged;
        n_fault = r_fault;
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        reg_we  = 1'b0;
        wb_en   = 1'b0;
        res     = '0;
        hexc    = (r_occ != '0) && r_fault[r_head];
        hrdy    = (r_occ != '0) && r_done[r_head] && r_aged[r_head];
        res.status         = ST_OK;
        res.head_exception = hexc;
        res.head_ready     = hrdy;

        case (t_mode'(i_item.mode))
            MODE_ALLOC: begin
                if (r_occ >= i_used) begin
                    res.status = ST_FULL;
                end else begin
                    n_valid[r_tail] = 1'b1;
                    n_done[r_tail]  = 1'b0;
                    n_aged[r_tail]  = 1'b0;
                    n_fault[r_tail] = 1'b0;
                    reg_we          = 1'b1;
                    res.out_index   = IDX_W'(r_tail);
                    n_tail          = adv(r_tail, i_used);
                    n_occ           = r_occ + CW'(1);
                end
            end
            MODE_WBACK: begin
                if (idx_ok) begin
                    wb_en         = 1'b1;
                    n_done[iaddr] = 1'b1;
                end
            end
            MODE_MARK: begin
                if (idx_ok) begin
                    n_fault[iaddr] = 1'b1;
                end
            end
            MODE_COMMIT: begin
                if (!hrdy) begin
                    res.status = ST_REFUSED;
                end else begin
                    res.out_index   = IDX_W'(r_head);
                    res.out_reg     = REG_W'(r_reg[r_head]);
                    res.out_value   = DATA_W'(i_head_data);
                    n_valid[r_head] = 1'b0;
                    n_done[r_head]  = 1'b0;
                    n_aged[r_head]  = 1'b0;
                    n_fault[r_head] = 1'b0;
                    n_head          = adv(r_head, i_used);
                    n_occ           = r_occ - CW'(1);
                end
            end
            MODE_FLUSH: begin
                n_valid = '0;
                n_done  = '0;
                n_aged  = '0;
                n_fault = '0;
                n_head  = '0;
                n_tail  = '0;
                n_occ   = '0;
            end
            MODE_TICK: begin
                n_aged = r_aged | (r_valid & r_done);
            end
            MODE_READ: begin
                if (idx_ok) begin
                    res.out_value   = DATA_W'(i_idx_data);
                    res.entry_ready = r_done[iaddr];
                end
            end
            default: begin
            end
        endcase

        res.is_empty = (n_occ == '0);
        res.is_full  = (n_occ >= i_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= '0;
            r_aged  <= '0;
            r_fault <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
        end else if (i_fire) begin
            r_valid <= n_valid;
            r_done  <= n_done;
            r_aged  <= n_aged;
            r_fault <= n_fault;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && reg_we) begin
            r_reg[r_tail] <= reg_wdata;
        end
    end

    assign o_result    = res;
    assign o_head_next = i_fire ? n_head : r_head;
    assign o_wr_en     = i_fire && wb_en;
    assign o_wr_addr   = iaddr;
    assign o_wr_data   = VALUE_BITS'(i_item.write_value);
endmodule

>>> rtl/core/reorder_buffer_with_commit_delay.sv
// Reorder buffer with commit delay: top level, input stage, result register, config.
// Depends on robcd_pkg, robcd_in_if, robcd_out_if, robcd_value_mem and robcd_ctrl.
// A transaction passes the input register, then the result register, before its result is valid.
// Throughput: one transaction per cycle unless o_out.ready stalls; single state stage in robcd_ctrl.
// Reset (synchronous, active low): clears flags, pointers, occupancy, valids; entries_in_use
// returns to 16. The register and value stores are not cleared.
module reorder_buffer_with_commit_delay #(
    parameter int ROB_DEPTH  = robcd_pkg::ROB_DEPTH_DEF,
    parameter int REG_COUNT  = robcd_pkg::REG_COUNT_DEF,
    parameter int VALUE_BITS = robcd_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [robcd_pkg::CFG_W-1:0]   i_cfg_wr_data,
    robcd_in_if.sink                      i_in,
    robcd_out_if.source                   o_out
);
    import robcd_pkg::*;

    localparam int PW = $clog2(ROB_DEPTH);
    localparam int CW = $clog2(ROB_DEPTH+1);

    // Configuration: entries_in_use, clamped into 1..ROB_DEPTH for use
    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    used;

    // Input stage and result register
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    fire;
    logic    accept;
    t_result result;

    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [PW-1:0]         head_next;
    logic [VALUE_BITS-1:0] head_data;
    logic [VALUE_BITS-1:0] idx_data;

    always_comb begin
        if (r_cfg == '0) begin
            used = CW'(1);
        end else if (32'(r_cfg) > 32'(ROB_DEPTH)) begin
            used = CW'(ROB_DEPTH);
        end else begin
            used = CW'(r_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // Advance the stored transaction when the result register is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.mode        <= i_in.mode;
            r_in.dest_reg    <= i_in.dest_reg;
            r_in.entry_index <= i_in.entry_index;
            r_in.write_value <= i_in.write_value;
        end
    end

    // Value reads launch with the accept: the head read uses the head as it will stand
    // after the transaction now in the stage, the indexed read uses the incoming index.
    robcd_value_mem #(
        .ROB_DEPTH  (ROB_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_value_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (accept),
        .i_rd_addr_a (head_next),
        .i_rd_addr_b (PW'(i_in.entry_index)),
        .o_rd_data_a (head_data),
        .o_rd_data_b (idx_data)
    );

    robcd_ctrl #(
        .ROB_DEPTH  (ROB_DEPTH),
        .REG_COUNT  (REG_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_used      (used),
        .i_head_data (head_data),
        .i_idx_data  (idx_data),
        .o_result    (result),
        .o_head_next (head_next),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Hold the result until taken; load a new one whenever the stage fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.out_index      = r_out.out_index;
    assign o_out.out_reg        = r_out.out_reg;
    assign o_out.out_value      = r_out.out_value;
    assign o_out.head_exception = r_out.head_exception;
    assign o_out.entry_ready    = r_out.entry_ready;
    assign o_out.head_ready     = r_out.head_ready;
    assign o_out.is_empty       = r_out.is_empty;
    assign o_out.is_full        = r_out.is_full;
endmodule

>>> rtl/core/robcd_checker.sv
// robcd_checker: port-level assertions on the result channel of the reorder buffer.
// Depends on robcd_pkg; bound to reorder_buffer_with_commit_delay at the end of this file.
module robcd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [robcd_pkg::STATUS_W-1:0] i_status,
    input logic signed [robcd_pkg::DATA_W-1:0] i_value,
    input logic                           i_head_ready,
    input logic                           i_is_empty,
    input logic                           i_is_full
);
    import robcd_pkg::*;

    a_reset_drop: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_value)))
        else $error("stalled result changed");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_FULL)) |-> i_is_full)
        else $error("full rejection without full flag");

    a_refused_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_REFUSED)) |-> !i_head_ready)
        else $error("commit refused while head ready");

    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_is_empty && i_is_full))
        else $error("buffer empty and full at once");
endmodule

bind reorder_buffer_with_commit_delay robcd_checker u_robcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_status     (o_out.status),
    .i_value      (o_out.out_value),
    .i_head_ready (o_out.head_ready),
    .i_is_empty   (o_out.is_empty),
    .i_is_full    (o_out.is_full)
);
